/* rtl/core/bbpr_pkg.sv */
`timescale 1ns / 1ps

package bbpr_pkg;

   // pool geometry
   localparam int MAX_BLOCKS = 1024;
   localparam int COUNT_BITS = 8;
   localparam int WORD_WIDTH = 32;
   localparam int BIT_BITS   = $clog2(WORD_WIDTH);
   localparam int WORD_COUNT = MAX_BLOCKS / WORD_WIDTH;
   localparam int WORD_BITS  = $clog2(WORD_COUNT);
   localparam int INDEX_BITS = $clog2(MAX_BLOCKS);
   localparam int SIZE_BITS  = INDEX_BITS + 1;
   localparam int HINT_BITS  = WORD_BITS + 1;
   localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

   // command codes
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_ADDREF  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

   typedef logic [WORD_WIDTH-1:0] map_word_type;

   // free map word w after init with size blocks: bit set where block < size
   function automatic map_word_type init_word(input logic [SIZE_BITS-1:0] size,
                                              input logic [WORD_BITS-1:0] w);
      map_word_type            r;
      logic [SIZE_BITS-1:0]    pos;
      r = '0;
      for (int b = 0; b < WORD_WIDTH; b++) begin
         pos  = SIZE_BITS'({w, b[BIT_BITS-1:0]});
         r[b] = (pos < size);
      end
      return r;
   endfunction

   // position of the highest set bit, by halving the window
   function automatic logic [BIT_BITS-1:0] high_bit(input map_word_type word);
      logic [BIT_BITS-1:0] p;
      logic [15:0]         v16;
      logic [7:0]          v8;
      logic [3:0]          v4;
      logic [1:0]          v2;
      p[4] = |word[31:16];
      v16  = p[4] ? word[31:16] : word[15:0];
      p[3] = |v16[15:8];
      v8   = p[3] ? v16[15:8] : v16[7:0];
      p[2] = |v8[7:4];
      v4   = p[2] ? v8[7:4] : v8[3:0];
      p[1] = |v4[3:2];
      v2   = p[1] ? v4[3:2] : v4[1:0];
      p[0] = v2[1];
      return p;
   endfunction

endpackage

/* rtl/core/bitmap_block_pool_refcount.sv */
`timescale 1ns / 1ps

// Block pool allocator: a free bitmap of 32-bit words plus a reference count
// per block. Request words (req_command, req_block_index) enter on req_valid
// when req_stall is low; each one gives exactly one response word on rsp_valid,
// held until rsp_stall is low. The pool size is written on the csr channel
// (csr_valid/csr_ready) only while the sequencer is idle; a write clamps the
// size to 1024, rebuilds the free map and clears the hint and usage counters.
// Release and add-reference pass through S_UPDATE and S_DONE to the output
// register; an index outside the pool or the unused command goes straight to
// S_DONE; allocate walks S_SCAN word by word from the hint, then S_PICK and
// S_DONE, and an allocate that finds no free block scans to the map end.
// The one word-read and priority-encode path of the sequencer handles one
// request at a time: a new request is taken only once the sequencer has
// registered the previous response and returned to idle.
// A waiting response sits in the output register; the next request is taken
// meanwhile and its result waits in the sequencer until rsp_stall drops.
// Synchronous reset sets a 1024-block pool with every block free; reference
// counts are not cleared and are defined by allocate.
module bitmap_block_pool_refcount (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [bbpr_pkg::INDEX_BITS-1:0] req_block_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bbpr_pkg::INDEX_BITS-1:0] rsp_granted_index,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_freed,
   output logic [bbpr_pkg::SIZE_BITS-1:0]  rsp_used_count,
   output logic [bbpr_pkg::SIZE_BITS-1:0]  rsp_used_peak,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bbpr_pkg::SIZE_BITS-1:0]  csr_pool_size
);
   import bbpr_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_UPDATE, S_DONE} state_type;

   state_type               state_ff, state_in;
   logic [SIZE_BITS-1:0]    pool_size_ff, pool_size_in;
   map_word_type            map_ff [WORD_COUNT];
   map_word_type            map_in [WORD_COUNT];
   logic [HINT_BITS-1:0]    hint_ff, hint_in;
   logic [SIZE_BITS-1:0]    in_use_ff, in_use_in;
   logic [SIZE_BITS-1:0]    peak_ff, peak_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0]   blk_ff, blk_in;
   logic [HINT_BITS-1:0]    ptr_ff, ptr_in;
   logic [INDEX_BITS-1:0]   gnt_ff, gnt_in;
   logic [1:0]              status_ff, status_in;
   logic                    freed_ff, freed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]   rsp_gnt_ff, rsp_gnt_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_freed_ff, rsp_freed_in;
   logic [SIZE_BITS-1:0]    rsp_used_ff, rsp_used_in;
   logic [SIZE_BITS-1:0]    rsp_peak_ff, rsp_peak_in;

   // reference count memory
   logic [COUNT_BITS-1:0]   cnt_mem [MAX_BLOCKS];
   logic [COUNT_BITS-1:0]   cnt_rd_ff;
   logic                    cnt_we;
   logic [INDEX_BITS-1:0]   cnt_wa;
   logic [COUNT_BITS-1:0]   cnt_wd;

   logic                    req_take;
   logic                    out_free;
   logic [SIZE_BITS-1:0]    size_clamped;
   map_word_type            sel_word;
   map_word_type            picked_word;
   logic [BIT_BITS-1:0]     pick_pos;
   logic [WORD_BITS-1:0]    blk_word;
   logic [SIZE_BITS-1:0]    in_use_inc;

   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign size_clamped = (csr_pool_size > SIZE_BITS'(MAX_BLOCKS)) ?
                         SIZE_BITS'(MAX_BLOCKS) : csr_pool_size;
   assign sel_word     = map_ff[ptr_ff[WORD_BITS-1:0]];
   assign pick_pos     = high_bit(sel_word);
   assign picked_word  = sel_word & ~(map_word_type'(1) << pick_pos);
   assign blk_word     = blk_ff[INDEX_BITS-1:BIT_BITS];
   assign in_use_inc   = (in_use_ff < SIZE_BITS'(MAX_BLOCKS)) ?
                         in_use_ff + SIZE_BITS'(1) : in_use_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_gnt_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_freed         = rsp_freed_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_used_peak     = rsp_peak_ff;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      pool_size_in  = pool_size_ff;
      map_in        = map_ff;
      hint_in       = hint_ff;
      in_use_in     = in_use_ff;
      peak_in       = peak_ff;
      cmd_in        = cmd_ff;
      blk_in        = blk_ff;
      ptr_in        = ptr_ff;
      gnt_in        = gnt_ff;
      status_in     = status_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_gnt_in    = rsp_gnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_peak_in   = rsp_peak_ff;
      cnt_we        = 1'b0;
      cnt_wa        = blk_ff;
      cnt_wd        = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               // pool re-init
               pool_size_in = size_clamped;
               for (int w = 0; w < WORD_COUNT; w++) begin
                  map_in[w] = init_word(size_clamped, w[WORD_BITS-1:0]);
               end
               hint_in   = '0;
               in_use_in = '0;
               peak_in   = '0;
            end else if (req_take) begin
               cmd_in    = req_command;
               blk_in    = req_block_index;
               ptr_in    = hint_ff;
               gnt_in    = '0;
               status_in = STATUS_OK;
               freed_in  = 1'b0;
               case (req_command)
                  CMD_ALLOC: state_in = S_SCAN;
                  CMD_RELEASE, CMD_ADDREF: begin
                     if (SIZE_BITS'(req_block_index) >= pool_size_ff) begin
                        status_in = STATUS_BAD_INDEX;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_UPDATE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // walk words from the hint until one holds a free bit or the map end is passed
         S_SCAN: begin
            if (ptr_ff[WORD_BITS]) begin
               status_in = STATUS_NO_FREE;
               state_in  = S_DONE;
            end else if (sel_word == '0) begin
               ptr_in = ptr_ff + HINT_BITS'(1);
            end else begin
               state_in = S_PICK;
            end
         end

         // take highest free bit, count starts at one
         S_PICK: begin
            map_in[ptr_ff[WORD_BITS-1:0]] = picked_word;
            hint_in   = (picked_word != '0) ? ptr_ff : ptr_ff + HINT_BITS'(1);
            gnt_in    = {ptr_ff[WORD_BITS-1:0], pick_pos};
            cnt_we    = 1'b1;
            cnt_wa    = {ptr_ff[WORD_BITS-1:0], pick_pos};
            cnt_wd    = COUNT_BITS'(1);
            in_use_in = in_use_inc;
            peak_in   = (in_use_inc > peak_ff) ? in_use_inc : peak_ff;
            state_in  = S_DONE;
         end

         // count read back, release or add a reference
         S_UPDATE: begin
            if (cmd_ff == CMD_RELEASE) begin
               if (cnt_rd_ff > COUNT_BITS'(1)) begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_rd_ff - COUNT_BITS'(1);
               end else begin
                  map_in[blk_word][blk_ff[BIT_BITS-1:0]] = 1'b1;
                  if (HINT_BITS'(blk_word) < hint_ff) begin
                     hint_in = HINT_BITS'(blk_word);
                  end
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - SIZE_BITS'(1);
                  end
                  freed_in = 1'b1;
               end
            end else begin
               if (cnt_rd_ff < COUNT_BITS'(COUNT_MAX)) begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_rd_ff + COUNT_BITS'(1);
               end
            end
            state_in = S_DONE;
         end

         // hand result to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_gnt_in    = gnt_ff;
               rsp_status_in = status_ff;
               rsp_freed_in  = freed_ff;
               rsp_used_in   = in_use_ff;
               rsp_peak_in   = peak_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pool_size_ff <= SIZE_BITS'(MAX_BLOCKS);
         for (int w = 0; w < WORD_COUNT; w++) begin
            map_ff[w] <= init_word(SIZE_BITS'(MAX_BLOCKS), w[WORD_BITS-1:0]);
         end
         hint_ff      <= '0;
         in_use_ff    <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         map_ff       <= map_in;
         hint_ff      <= hint_in;
         in_use_ff    <= in_use_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      blk_ff        <= blk_in;
      ptr_ff        <= ptr_in;
      gnt_ff        <= gnt_in;
      status_ff     <= status_in;
      freed_ff      <= freed_in;
      rsp_gnt_ff    <= rsp_gnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   // count memory, read issued as the request is taken
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (req_take) begin
         cnt_rd_ff <= cnt_mem[req_block_index];
      end
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= SIZE_BITS'(MAX_BLOCKS))
      else $error("in-use count above pool capacity");

   assert property (@(posedge clock) disable iff (reset)
      peak_ff >= in_use_ff)
      else $error("peak below current in-use count");

   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("sequencer idle after taking a request");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |-> (sel_word != '0))
      else $error("pick from an empty map word");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
         (!rsp_freed_ff && (rsp_gnt_ff == '0)))
      else $error("failed response carries a grant or a free");

endmodule
